@@ sv/i2p_pkg.sv @@
// i2p_pkg: item types, codes and character helpers for the infix to postfix converter
// no dependencies; imported by i2p_core and infix_to_postfix_converter

package i2p_pkg;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW   = 2'd1;
  localparam logic [1:0] STATUS_UNMATCHED  = 2'd2;

  localparam logic [7:0] CH_OPEN_PAREN   = 8'h28;
  localparam logic [7:0] CH_CLOSE_PAREN  = 8'h29;
  localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
  localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
  localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
  localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;
  localparam logic [7:0] CH_PLUS         = 8'h2B;
  localparam logic [7:0] CH_MINUS        = 8'h2D;
  localparam logic [7:0] CH_STAR         = 8'h2A;
  localparam logic [7:0] CH_SLASH        = 8'h2F;
  localparam logic [7:0] CH_CARET        = 8'h5E;

  localparam logic [2:0] PRIO_NONE = 3'd0;
  localparam logic [2:0] PRIO_ADD  = 3'd2;
  localparam logic [2:0] PRIO_MUL  = 3'd3;
  localparam logic [2:0] PRIO_POW  = 3'd4;

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_expr;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_symbol;
    logic       has_symbol;
    logic       run_last;
    logic       expr_done;
    logic [1:0] status;
  } out_item_t;

  // handshake between the sequencer and the output register
  typedef struct packed {
    logic in_ready;
    logic res_valid;
  } core_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_LAST
  } state_t;

  typedef enum logic [1:0] {
    MD_CLOSE,
    MD_OP,
    MD_FLUSH
  } mode_t;

  typedef enum logic [2:0] {
    CL_OPERAND,
    CL_OPEN,
    CL_CLOSE,
    CL_OPER,
    CL_OTHER
  } char_class_t;

  function automatic logic is_open_br(input logic [7:0] c);
    return (c == CH_OPEN_PAREN) || (c == CH_OPEN_SQUARE) || (c == CH_OPEN_CURLY);
  endfunction

  function automatic logic is_close_br(input logic [7:0] c);
    return (c == CH_CLOSE_PAREN) || (c == CH_CLOSE_SQUARE) || (c == CH_CLOSE_CURLY);
  endfunction

  function automatic logic is_operand(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A)) ||
           ((c >= 8'h30) && (c <= 8'h39));
  endfunction

  function automatic logic [2:0] prio(input logic [7:0] c);
    logic [2:0] p;
    p = PRIO_NONE;
    if ((c == CH_PLUS) || (c == CH_MINUS)) p = PRIO_ADD;
    if ((c == CH_STAR) || (c == CH_SLASH)) p = PRIO_MUL;
    if (c == CH_CARET) p = PRIO_POW;
    return p;
  endfunction

  function automatic char_class_t char_class(input logic [7:0] c);
    char_class_t cl;
    cl = CL_OTHER;
    if (is_operand(c)) cl = CL_OPERAND;
    else if (is_open_br(c)) cl = CL_OPEN;
    else if (is_close_br(c)) cl = CL_CLOSE;
    else if (prio(c) != PRIO_NONE) cl = CL_OPER;
    return cl;
  endfunction

endpackage

@@ sv/infix_to_postfix_converter.sv @@
// infix_to_postfix_converter: top level, output register around the conversion sequencer
// depends on i2p_pkg and i2p_core
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall  | in_item  (symbol, end_of_expr)
//   out_    | output    | out_valid / out_stall| out_item (out_symbol, has_symbol,
//           |           |                      |   run_last, expr_done, status)
//
// each stack entry that an item needs is read through the single ram read port in S_RD
// and checked in S_CHK (popped, discarded, or left in place); the operator or bracket
// scan or the end-of-expression flush also passes through S_RD when it finds the stack empty
// in_stall stays high until the last result of the item sits in the output register
// out_stall holds the output register; the sequencer waits whenever it must hand over
// a result while the register is full and out_stall is high
// synchronous active-low reset empties the stack; no clearing pass is needed

module infix_to_postfix_converter
  import i2p_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  core_ctl_t ctl;
  out_item_t res;
  logic      out_free;
  logic      out_valid_r;
  out_item_t out_item_r;

  assign out_free = !out_valid_r || !out_stall;

  i2p_core #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_item  (in_item),
    .out_free (out_free),
    .ctl      (ctl),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.res_valid) begin
      out_item_r <= res;
    end
  end

  assign in_stall  = !ctl.in_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ sv/i2p_ram.sv @@
// i2p_ram: generic single write port, single read port ram with registered read
// no dependencies; holds the operator stack

module i2p_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/i2p_core.sv @@
// i2p_core: sequencer for the shunting-yard conversion, one stack entry per read and check
// depends on i2p_pkg and i2p_ram

module i2p_core
  import i2p_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  in_item_t  in_item,
  input  logic      out_free,
  output core_ctl_t ctl,
  output out_item_t res
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  state_t          state_r, state_nxt;
  mode_t           mode_r, mode_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   open_cnt_r, open_cnt_nxt;
  logic [7:0]      sym_r, sym_nxt;
  logic            end_r, end_nxt;
  logic [1:0]      status_r, status_nxt;
  logic [7:0]      pend_sym_r, pend_sym_nxt;
  logic            pend_v_r, pend_v_nxt;

  logic            we, re;
  logic [AW-1:0]   waddr, raddr;
  logic [7:0]      wdata, rdata;
  logic [CW-1:0]   cnt_m1;
  logic            in_fire;
  char_class_t     in_cl;
  logic            top_open;
  logic            do_emit;
  logic            char_done;

  i2p_ram #(
    .WIDTH (8),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign cnt_m1   = count_r - 1'b1;
  assign in_fire  = in_valid && (state_r == S_IDLE);
  assign in_cl    = char_class(in_item.symbol);
  assign top_open = is_open_br(rdata);
  // operator mode pops only while the top has equal or higher priority
  assign do_emit  = !top_open && ((mode_r != MD_OP) || (prio(rdata) >= prio(sym_r)));
  assign char_done = (mode_r != MD_FLUSH) &&
                     (((state_r == S_RD) && (count_r == '0)) ||
                      ((state_r == S_CHK) && !do_emit));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if ((in_cl == CL_OPER) || (in_cl == CL_CLOSE) || in_item.end_of_expr) begin
            state_nxt = S_RD;
          end else begin
            state_nxt = S_LAST;
          end
        end
      end
      S_RD: begin
        if (count_r != '0) begin
          state_nxt = S_CHK;
        end else if (mode_r == MD_FLUSH) begin
          state_nxt = S_LAST;
        end else begin
          state_nxt = end_r ? S_RD : S_LAST;
        end
      end
      S_CHK: begin
        if (do_emit) begin
          if (!pend_v_r || out_free) state_nxt = S_RD;
        end else if (mode_r == MD_FLUSH) begin
          state_nxt = S_RD;
        end else begin
          state_nxt = end_r ? S_RD : S_LAST;
        end
      end
      S_LAST: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    mode_nxt     = mode_r;
    count_nxt    = count_r;
    open_cnt_nxt = open_cnt_r;
    sym_nxt      = sym_r;
    end_nxt      = end_r;
    status_nxt   = status_r;
    pend_sym_nxt = pend_sym_r;
    pend_v_nxt   = pend_v_r;
    we           = 1'b0;
    waddr        = count_r[AW-1:0];
    wdata        = sym_r;
    re           = 1'b0;
    raddr        = cnt_m1[AW-1:0];
    ctl.in_ready = (state_r == S_IDLE);
    ctl.res_valid = 1'b0;
    res          = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          sym_nxt    = in_item.symbol;
          end_nxt    = in_item.end_of_expr;
          status_nxt = STATUS_OK;
          pend_v_nxt = 1'b0;
          mode_nxt   = MD_FLUSH;
          unique case (in_cl)
            CL_OPERAND: begin
              pend_sym_nxt = in_item.symbol;
              pend_v_nxt   = 1'b1;
            end
            CL_OPEN: begin
              if (count_r == FULL) begin
                status_nxt = STATUS_OVERFLOW;
              end else begin
                we           = 1'b1;
                wdata        = in_item.symbol;
                count_nxt    = count_r + 1'b1;
                open_cnt_nxt = open_cnt_r + 1'b1;
              end
            end
            CL_CLOSE: begin
              mode_nxt = MD_CLOSE;
              // no opening bracket anywhere on the stack
              if (open_cnt_r == '0) status_nxt = STATUS_UNMATCHED;
            end
            CL_OPER: begin
              mode_nxt = MD_OP;
            end
            CL_OTHER: begin
            end
            default: begin
            end
          endcase
        end
      end
      S_RD: begin
        if (count_r != '0) begin
          re = 1'b1;
        end else if (mode_r == MD_OP) begin
          we        = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      S_CHK: begin
        if (do_emit) begin
          if (!pend_v_r || out_free) begin
            ctl.res_valid = pend_v_r;
            res = '{out_symbol: pend_sym_r, has_symbol: 1'b1, run_last: 1'b0,
                    expr_done: 1'b0, status: status_r};
            pend_sym_nxt = rdata;
            pend_v_nxt   = 1'b1;
            count_nxt    = cnt_m1;
          end
        end else if (mode_r == MD_OP) begin
          if (count_r == FULL) begin
            status_nxt = STATUS_OVERFLOW;
          end else begin
            we        = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end else begin
          // opening bracket on top is discarded
          count_nxt    = cnt_m1;
          open_cnt_nxt = open_cnt_r - 1'b1;
        end
      end
      S_LAST: begin
        if (out_free) begin
          ctl.res_valid = 1'b1;
          res = '{out_symbol: pend_v_r ? pend_sym_r : 8'h00, has_symbol: pend_v_r,
                  run_last: 1'b1, expr_done: end_r, status: status_r};
          pend_v_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase

    if (char_done && end_r) mode_nxt = MD_FLUSH;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      mode_r     <= MD_FLUSH;
      count_r    <= '0;
      open_cnt_r <= '0;
      pend_v_r   <= 1'b0;
      status_r   <= STATUS_OK;
      end_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      mode_r     <= mode_nxt;
      count_r    <= count_nxt;
      open_cnt_r <= open_cnt_nxt;
      pend_v_r   <= pend_v_nxt;
      status_r   <= status_nxt;
      end_r      <= end_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r      <= sym_nxt;
    pend_sym_r <= pend_sym_nxt;
  end

endmodule
